FILE: rtl/bgbd_pkg.sv
package bgbd_pkg;

   localparam int NumDenomDefault = 8;
   localparam int ValueWidth      = 16;
   localparam int CountWidth      = 16;
   localparam int AmountWidth     = 20;
   localparam int StatusWidth     = 2;
   localparam int TxnWidth        = 16;

   localparam logic [StatusWidth-1:0] STATUS_OK       = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_NOT_PAID = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_FULL     = 2'd2;
   localparam logic [StatusWidth-1:0] STATUS_BAD      = 2'd3;

   localparam logic ACTION_ADD      = 1'b0;
   localparam logic ACTION_WITHDRAW = 1'b1;

   typedef struct packed {
      logic add_start;
      logic wd_start;
      logic select_step;
      logic div_start;
      logic take_step;
      logic commit_start;
      logic commit_step;
      logic emit_status;
      logic counter_inc;
   } cmd_type;

   typedef struct packed {
      logic add_done;
      logic select_found;
      logic div_done;
      logic paid_off;
      logic commit_has;
      logic commit_last;
      logic any_used;
   } stat_type;

endpackage

FILE: rtl/bgbd_ctrl.sv
module bgbd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bgbd_pkg::cmd_type cmd,
   input  bgbd_pkg::stat_type stat
);
   import bgbd_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ADD    = 3'd1;
   localparam logic [2:0] ST_SELECT = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;
   localparam logic [2:0] ST_STATUS = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy_in  = busy_ff;
      req_ready = (state_ff == ST_IDLE) && !busy_ff;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               busy_in = 1'b1;
               if (req_action == ACTION_ADD) begin
                  cmd.add_start = 1'b1;
                  state_in = ST_ADD;
               end else begin
                  cmd.wd_start = 1'b1;
                  state_in = ST_SELECT;
               end
            end
         end
         ST_ADD: begin
            if (stat.add_done) begin
               cmd.emit_status = 1'b1;
               state_in = ST_STATUS;
            end
         end
         ST_SELECT: begin
            if (stat.paid_off || !stat.select_found) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.select_step = 1'b1;
               cmd.div_start   = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               cmd.take_step = 1'b1;
               state_in = ST_SELECT;
            end
         end
         ST_DECIDE: begin
            if (stat.paid_off && stat.any_used) begin
               cmd.counter_inc  = 1'b1;
               cmd.commit_start = 1'b1;
               state_in = ST_EMIT;
            end else begin
               cmd.counter_inc = stat.paid_off;
               cmd.emit_status = 1'b1;
               state_in = ST_STATUS;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.commit_step = 1'b1;
               if (stat.commit_last) begin
                  state_in = ST_IDLE;
                  busy_in  = 1'b0;
               end
            end
         end
         ST_STATUS: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
               busy_in  = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            busy_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

`ifndef SYNTH
   ap_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready while result pending");
   ap_one_start: assert property (@(posedge clock) disable iff (reset)
      !(cmd.add_start && cmd.wd_start))
      else $error("two starts");
   ap_emit_has: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> stat.commit_has)
      else $error("emit with nothing to pay");
`endif
endmodule

FILE: rtl/bgbd_datapath.sv
module bgbd_datapath #(
   parameter int NUM_DENOMINATIONS = bgbd_pkg::NumDenomDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bgbd_pkg::cmd_type                   cmd,
   output bgbd_pkg::stat_type                  stat,
   input  logic [bgbd_pkg::ValueWidth-1:0]     req_bill_value,
   input  logic [bgbd_pkg::CountWidth-1:0]     req_bill_count,
   input  logic [bgbd_pkg::AmountWidth-1:0]    req_amount,
   output logic [bgbd_pkg::StatusWidth-1:0]    rsp_status,
   output logic [bgbd_pkg::ValueWidth-1:0]     rsp_paid_value,
   output logic [bgbd_pkg::CountWidth-1:0]     rsp_paid_count,
   output logic [bgbd_pkg::TxnWidth-1:0]       rsp_transaction_number,
   output logic                                rsp_last
);
   import bgbd_pkg::*;

   localparam int N  = NUM_DENOMINATIONS;
   localparam int IW = (N > 1) ? $clog2(N) : 1;
   localparam int CW = $clog2(AmountWidth + 1);

   logic [ValueWidth-1:0] denom_ff [N];
   logic [ValueWidth-1:0] denom_in [N];
   logic [CountWidth-1:0] stock_ff [N];
   logic [CountWidth-1:0] stock_in [N];
   logic [N-1:0] used_ff, used_in;
   logic [N-1:0] visited_ff, visited_in;
   logic [N-1:0] take_mask_ff, take_mask_in;
   logic [CountWidth-1:0] take_ff [N];
   logic [CountWidth-1:0] take_in [N];
   logic [TxnWidth-1:0]    txn_ff, txn_in;
   logic [AmountWidth-1:0] rem_ff, rem_in;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic [IW-1:0]          cur_ff, cur_in;
   logic [ValueWidth-1:0]  add_value_ff, add_value_in;
   logic [CountWidth-1:0]  add_count_ff, add_count_in;

   logic [AmountWidth-1:0] quo_ff, quo_in;
   logic [AmountWidth:0]   part_ff, part_in;
   logic [CW-1:0]          bit_ff, bit_in;
   logic                   div_run_ff, div_run_in;

   logic              found;
   logic [IW-1:0]     best;
   logic              hit;
   logic [IW-1:0]     hit_idx;
   logic              free_ok;
   logic [IW-1:0]     free_idx;
   logic [CountWidth:0] add_sum;
   logic [AmountWidth:0] part_shift;
   logic [AmountWidth-1:0] quo_clip;
   logic [CountWidth-1:0]  q_take;
   logic [AmountWidth+CountWidth-1:0] prod;
   logic [IW-1:0]     next_c;
   logic              has_c;
   logic              more_c;

   logic                   stat_is_add_ff, stat_is_add_in;
   logic [StatusWidth-1:0] add_status;
   logic [IW-1:0]          first_idx;
   logic                   first_has;

   always_comb begin
      found = 1'b0;
      best  = '0;
      hit   = 1'b0;
      hit_idx = '0;
      free_ok = 1'b0;
      free_idx = '0;
      for (int i = 0; i < N; i++) begin
         if (used_ff[i] && !visited_ff[i] && denom_ff[i] != '0 &&
             (!found || denom_ff[i] > denom_ff[best])) begin
            found = 1'b1;
            best  = IW'(i);
         end
         if (used_ff[i] && denom_ff[i] == add_value_ff && !hit) begin
            hit = 1'b1;
            hit_idx = IW'(i);
         end
         if (!used_ff[i] && !free_ok) begin
            free_ok = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   always_comb begin
      has_c  = 1'b0;
      next_c = '0;
      more_c = 1'b0;
      for (int i = N - 1; i >= 0; i--) begin
         if (take_mask_ff[i] && IW'(i) != cur_ff) begin
            if (denom_ff[i] < denom_ff[cur_ff]) begin
               if (!has_c || denom_ff[i] > denom_ff[next_c]) begin
                  has_c  = 1'b1;
                  next_c = IW'(i);
               end
            end
         end
      end
      more_c = has_c;
   end

   assign add_sum    = {1'b0, stock_ff[hit_idx]} + {1'b0, add_count_ff};
   assign part_shift = {part_ff[AmountWidth-1:0], rem_ff[bit_ff - CW'(1)]};
   assign quo_clip   = (quo_ff > AmountWidth'(stock_ff[cur_ff])) ?
                       AmountWidth'(stock_ff[cur_ff]) : quo_ff;
   assign q_take     = quo_clip[CountWidth-1:0];
   assign prod       = AmountWidth'(quo_clip) * denom_ff[cur_ff];

   always_comb begin
      denom_in     = denom_ff;
      stock_in     = stock_ff;
      used_in      = used_ff;
      visited_in   = visited_ff;
      take_mask_in = take_mask_ff;
      take_in      = take_ff;
      txn_in       = txn_ff;
      rem_in       = rem_ff;
      status_in    = status_ff;
      cur_in       = cur_ff;
      add_value_in = add_value_ff;
      add_count_in = add_count_ff;
      quo_in       = quo_ff;
      part_in      = part_ff;
      bit_in       = bit_ff;
      div_run_in   = 1'b0;

      if (cmd.add_start) begin
         add_value_in = req_bill_value;
         add_count_in = req_bill_count;
      end
      if (cmd.wd_start) begin
         rem_in       = req_amount;
         visited_in   = '0;
         take_mask_in = '0;
      end
      if (cmd.select_step) begin
         visited_in[best] = 1'b1;
         cur_in     = best;
      end
      if (cmd.div_start) begin
         quo_in     = '0;
         part_in    = '0;
         bit_in     = CW'(AmountWidth);
         div_run_in = 1'b1;
      end
      if (div_run_ff) begin
         if (part_shift >= {1'b0, 4'b0, denom_ff[cur_ff]}) begin
            part_in = part_shift - {5'b0, denom_ff[cur_ff]};
            quo_in  = {quo_ff[AmountWidth-2:0], 1'b1};
         end else begin
            part_in = part_shift;
            quo_in  = {quo_ff[AmountWidth-2:0], 1'b0};
         end
         bit_in     = bit_ff - CW'(1);
         div_run_in = (bit_ff != CW'(1));
      end
      if (cmd.take_step && q_take != '0) begin
         rem_in = rem_ff - prod[AmountWidth-1:0];
         take_mask_in[cur_ff] = 1'b1;
         take_in[cur_ff] = q_take;
      end
      if (cmd.counter_inc) begin
         txn_in = txn_ff + TxnWidth'(1);
      end
      if (cmd.commit_start) begin
         status_in = STATUS_OK;
         cur_in = first_idx;
      end
      if (cmd.commit_step) begin
         stock_in[cur_ff] = stock_ff[cur_ff] - take_ff[cur_ff];
         cur_in = next_c;
      end
      if (cmd.emit_status) begin
         if (stat_is_add_ff) begin
            status_in = add_status;
            if (add_status == STATUS_OK) begin
               if (hit) begin
                  stock_in[hit_idx] = add_sum[CountWidth-1:0];
               end else begin
                  used_in[free_idx]  = 1'b1;
                  denom_in[free_idx] = add_value_ff;
                  stock_in[free_idx] = add_count_ff;
               end
            end
         end else begin
            status_in = (rem_ff == '0) ? STATUS_OK : STATUS_NOT_PAID;
         end
      end
   end

   always_comb begin
      if (add_value_ff == '0)       add_status = STATUS_BAD;
      else if (hit)                 add_status = add_sum[CountWidth] ? STATUS_BAD : STATUS_OK;
      else if (!free_ok)            add_status = STATUS_FULL;
      else                          add_status = STATUS_OK;
   end

   always_comb begin
      first_has = 1'b0;
      first_idx = '0;
      for (int i = 0; i < N; i++) begin
         if (take_mask_ff[i] && (!first_has || denom_ff[i] > denom_ff[first_idx])) begin
            first_has = 1'b1;
            first_idx = IW'(i);
         end
      end
   end

   assign stat_is_add_in = cmd.add_start ? 1'b1 : (cmd.wd_start ? 1'b0 : stat_is_add_ff);

   always_comb begin
      stat.add_done     = 1'b1;
      stat.select_found = found;
      stat.div_done     = !div_run_ff;
      stat.paid_off     = (rem_ff == '0);
      stat.commit_has   = take_mask_ff[cur_ff];
      stat.commit_last  = !more_c;
      stat.any_used     = first_has;
   end

   logic rsp_is_pay;
   assign rsp_is_pay = !stat_is_add_ff && (status_ff == STATUS_OK) && take_mask_ff[cur_ff]
                       && first_has;
   assign rsp_status             = status_ff;
   assign rsp_paid_value         = rsp_is_pay ? denom_ff[cur_ff] : '0;
   assign rsp_paid_count         = rsp_is_pay ? take_ff[cur_ff] : '0;
   assign rsp_transaction_number = txn_ff;
   assign rsp_last               = rsp_is_pay ? !more_c : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         txn_ff     <= '0;
         div_run_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            denom_ff[i] <= '0;
            stock_ff[i] <= '0;
         end
         take_mask_ff   <= '0;
         stat_is_add_ff <= 1'b1;
         status_ff      <= STATUS_OK;
      end else begin
         used_ff        <= used_in;
         txn_ff         <= txn_in;
         div_run_ff     <= div_run_in;
         denom_ff       <= denom_in;
         stock_ff       <= stock_in;
         take_mask_ff   <= cmd.commit_step && !more_c ? '0 : take_mask_in;
         stat_is_add_ff <= stat_is_add_in;
         status_ff      <= status_in;
      end
      visited_ff   <= visited_in;
      take_ff      <= take_in;
      rem_ff       <= rem_in;
      cur_ff       <= cur_in;
      add_value_ff <= add_value_in;
      add_count_ff <= add_count_in;
      quo_ff       <= quo_in;
      part_ff      <= part_in;
      bit_ff       <= bit_in;
   end

`ifndef SYNTH
   ap_rem_drop: assert property (@(posedge clock) disable iff (reset)
      cmd.take_step |=> rem_ff <= $past(rem_ff))
      else $error("remaining grew");
   ap_txn_step: assert property (@(posedge clock) disable iff (reset)
      cmd.counter_inc |=> txn_ff == $past(txn_ff) + TxnWidth'(1))
      else $error("counter step");
   ap_txn_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.counter_inc |=> $stable(txn_ff))
      else $error("counter moved");
`endif
endmodule

FILE: rtl/bounded_greedy_bill_dispense_top.sv
// channel | valid     | ready     | payload
// req     | req_valid | req_ready | action, bill_value, bill_count, amount
// rsp     | rsp_valid | rsp_ready | status, paid_value, paid_count,
//         |           |           | transaction_number, last
// Add: after accept the table is updated, then the status word is sent.
// Withdraw: select, 20 restoring divide steps and take per denomination
// visited, a decide state, then one result word per cycle with rsp_ready.
// One item at a time; reset is synchronous and empties the table.
// A stalled rsp_ready holds the current word and the whole block.
module bounded_greedy_bill_dispense_top #(
   parameter int NUM_DENOMINATIONS = bgbd_pkg::NumDenomDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [bgbd_pkg::ValueWidth-1:0]      req_bill_value,
   input  logic [bgbd_pkg::CountWidth-1:0]      req_bill_count,
   input  logic [bgbd_pkg::AmountWidth-1:0]     req_amount,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bgbd_pkg::StatusWidth-1:0]     rsp_status,
   output logic [bgbd_pkg::ValueWidth-1:0]      rsp_paid_value,
   output logic [bgbd_pkg::CountWidth-1:0]      rsp_paid_count,
   output logic [bgbd_pkg::TxnWidth-1:0]        rsp_transaction_number,
   output logic                                 rsp_last
);
   import bgbd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bgbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .stat       (stat)
   );

   bgbd_datapath #(
      .NUM_DENOMINATIONS (NUM_DENOMINATIONS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .stat                   (stat),
      .req_bill_value         (req_bill_value),
      .req_bill_count         (req_bill_count),
      .req_amount             (req_amount),
      .rsp_status             (rsp_status),
      .rsp_paid_value         (rsp_paid_value),
      .rsp_paid_count         (rsp_paid_count),
      .rsp_transaction_number (rsp_transaction_number),
      .rsp_last               (rsp_last)
   );
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import bgbd_pkg::*;

   localparam int NumSlots = 8;
   localparam int IdleLimit = 20000;
   localparam int HoldCycles = 2000;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [ValueWidth-1:0]  paid_value;
      logic [CountWidth-1:0]  paid_count;
      logic [TxnWidth-1:0]    txn;
      logic                   last;
   } payout_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic [ValueWidth-1:0] req_bill_value = '0;
   logic [CountWidth-1:0] req_bill_count = '0;
   logic [AmountWidth-1:0] req_amount = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [StatusWidth-1:0] rsp_status;
   logic [ValueWidth-1:0] rsp_paid_value;
   logic [CountWidth-1:0] rsp_paid_count;
   logic [TxnWidth-1:0] rsp_transaction_number;
   logic rsp_last;

   bounded_greedy_bill_dispense_top u_top (.*);

   always #2 clock = ~clock;

   logic [ValueWidth-1:0] denom_q [NumSlots];
   logic [CountWidth-1:0] stock_q [NumSlots];
   logic                  used_q  [NumSlots];
   logic [TxnWidth-1:0]   withdraw_cnt;
   payout_type payouts_due [$];
   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic hold_go = 1'b0;
   logic hold_taken = 1'b0;
   int hold_recv = 0;
   int idle_cycles = 0;

   function automatic payout_type mk(logic [1:0] st, logic [15:0] v, logic [15:0] c, logic l);
      payout_type p;
      p.status = st; p.paid_value = v; p.paid_count = c; p.txn = withdraw_cnt; p.last = l;
      return p;
   endfunction

   function automatic void queue_payout(payout_type p);
      payouts_due = {payouts_due, p};
   endfunction

   function automatic void predict_payout(logic act, logic [15:0] v, logic [15:0] c,
                                          logic [19:0] amt);
      int free_slot;
      logic [1:0] st;
      logic seen [NumSlots];
      int pick [NumSlots];
      logic [15:0] take [NumSlots];
      int n;
      int best;
      logic [19:0] rem;
      logic [19:0] q;
      logic done;
      free_slot = -1; n = 0; rem = amt; done = 1'b0; st = STATUS_OK;
      if (act == ACTION_ADD) begin
         if (v == 0) begin
            st = STATUS_BAD; done = 1'b1;
         end
         for (int i = 0; i < NumSlots && !done; i++) begin
            if (used_q[i] && denom_q[i] == v) begin
               if (32'(stock_q[i]) + 32'(c) > 32'hFFFF) st = STATUS_BAD;
               else stock_q[i] = stock_q[i] + c;
               done = 1'b1;
            end else if (!used_q[i] && free_slot < 0) begin
               free_slot = i;
            end
         end
         if (!done) begin
            if (free_slot < 0) st = STATUS_FULL;
            else begin
               used_q[free_slot] = 1'b1; denom_q[free_slot] = v; stock_q[free_slot] = c;
            end
         end
         queue_payout(mk(st, 0, 0, 1'b1));
         return;
      end
      foreach (seen[i]) seen[i] = 1'b0;
      for (int k = 0; k < NumSlots && rem != 0; k++) begin
         best = -1;
         for (int i = 0; i < NumSlots; i++)
            if (used_q[i] && !seen[i] && denom_q[i] != 0 &&
                (best < 0 || denom_q[i] > denom_q[best])) best = i;
         if (best < 0) break;
         seen[best] = 1'b1;
         q = rem / denom_q[best];
         if (q > stock_q[best]) q = stock_q[best];
         if (q > 0) begin
            rem = rem - q * denom_q[best];
            pick[n] = best; take[n] = q[15:0]; n++;
         end
      end
      if (rem != 0) begin
         queue_payout(mk(STATUS_NOT_PAID, 0, 0, 1'b1));
         return;
      end
      withdraw_cnt = withdraw_cnt + 1'b1;
      if (n == 0) queue_payout(mk(STATUS_OK, 0, 0, 1'b1));
      for (int k = 0; k < n; k++) begin
         stock_q[pick[k]] = stock_q[pick[k]] - take[k];
         queue_payout(mk(STATUS_OK, denom_q[pick[k]], take[k], k == n - 1));
      end
   endfunction

   task automatic send_word(logic act, logic [15:0] v, logic [15:0] c, logic [19:0] amt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1; req_action <= act;
      req_bill_value <= v; req_bill_count <= c; req_amount <= amt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_payout(act, v, c, amt);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (payouts_due.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_recv  <= HoldCycles;
         rsp_ready  <= 1'b0;
      end else if (hold_recv > 0) begin
         hold_recv <= hold_recv - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         payout_type got;
         payout_type want;
         got = {rsp_status, rsp_paid_value, rsp_paid_count, rsp_transaction_number, rsp_last};
         if (payouts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", got);
         end else begin
            want = payouts_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp st=%0d v=%0d c=%0d t=%0d l=%0d ",
                     want.status, want.paid_value, want.paid_count, want.txn, want.last,
                     "got st=%0d v=%0d c=%0d t=%0d l=%0d",
                     got.status, got.paid_value, got.paid_count, got.txn, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   function automatic logic [15:0] rand_value();
      int r;
      r = $urandom_range(9);
      if (r < 6) return 16'($urandom_range(1, 12) * ($urandom_range(3) == 0 ? 100 : 1));
      if (r < 8) return 16'($urandom_range(1, 500));
      return 16'($urandom);
   endfunction

   task automatic test_directed();
      send_word(ACTION_WITHDRAW, 16'hFFFF, 16'hFFFF, 20'd0);
      send_word(ACTION_WITHDRAW, 0, 0, 20'd5);
      send_word(ACTION_ADD, 16'd0, 16'd5, 20'hFFFFF);
      send_word(ACTION_ADD, 16'd50, 16'd0, 20'd0);
      send_word(ACTION_ADD, 16'd50, 16'hFFFF, 20'd0);
      send_word(ACTION_ADD, 16'd50, 16'd1, 20'd0);
      send_word(ACTION_ADD, 16'hFFFF, 16'd3, 20'd0);
      send_word(ACTION_ADD, 16'd1, 16'd10, 20'd0);
      send_word(ACTION_ADD, 16'd20, 16'd2, 20'd0);
      send_word(ACTION_ADD, 16'd10, 16'd4, 20'd0);
      send_word(ACTION_ADD, 16'd5, 16'd4, 20'd0);
      send_word(ACTION_ADD, 16'd2, 16'd4, 20'd0);
      send_word(ACTION_ADD, 16'd100, 16'd4, 20'd0);
      send_word(ACTION_ADD, 16'd7, 16'd4, 20'd0);
      send_word(ACTION_WITHDRAW, 0, 0, 20'd3);
      send_word(ACTION_WITHDRAW, 0, 0, 20'hFFFFF);
      send_word(ACTION_WITHDRAW, 0, 0, 20'd65535 + 20'd178);
      send_word(ACTION_WITHDRAW, 0, 0, 20'd999);
      send_word(ACTION_ADD, 16'd100, 16'hFFFF, 20'd0);
      send_word(ACTION_ADD, 16'd1, 16'd65000, 20'd0);
      send_word(ACTION_WITHDRAW, 16'd5, 16'd5, 20'd65000);
      wait_drained();
   endtask

   task automatic test_random(int n);
      logic [19:0] amt;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 35) begin
            send_word(ACTION_ADD, rand_value(), 16'($urandom_range(9) == 0 ? $urandom :
                      $urandom_range(20)), 20'($urandom));
         end else begin
            case ($urandom_range(5))
               0: amt = 20'($urandom);
               1: amt = 20'($urandom_range(3));
               default: amt = 20'($urandom_range(400));
            endcase
            send_word(ACTION_WITHDRAW, 16'($urandom), 16'($urandom), amt);
         end
      end
   endtask

   task automatic test_backpressure();
      hold_go = 1'b1;
      test_random(20);
      wait_drained();
   endtask

   initial begin
      foreach (denom_q[i]) begin
         denom_q[i] = '0; stock_q[i] = '0; used_q[i] = 1'b0;
      end
      withdraw_cnt = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 20; recv_idle_pct = 78;
      test_random(130);
      send_idle_pct = 78; recv_idle_pct = 20;
      test_random(130);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_backpressure();
      test_random(130);
      wait_drained();
      if (mismatches == 0 && payouts_due.size() == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end
endmodule
